FILE: rtl/stou_pkg.sv
package stou_pkg;

  // default accumulator width and character index limit
  localparam int WORD_BITS_DEF = 64;
  localparam longint unsigned MAX_CHARS = 64'd65535;
  localparam logic [15:0] IDX_LIMIT = (MAX_CHARS < 64'd65535) ? MAX_CHARS[15:0] : 16'hFFFF;

  localparam logic [5:0] DIGIT_NONE = 6'd63;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_BAD = 6'd1;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_DEC = 6'd10;
  localparam logic [5:0] RADIX_HEX = 6'd16;
  localparam logic [5:0] RADIX_AUTO = 6'd0;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LX = 8'h78;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BADRADIX = 2'd2,
    ST_MINUS    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] character;
    logic [5:0] radix;
    logic       last;
  } stou_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_offset;
    logic [1:0]  status;
  } stou_out_t;

  // digit value of a character, DIGIT_NONE when not a digit
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
    end else begin
      t = {2'b00, DIGIT_NONE};
    end
    return t[5:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

FILE: rtl/string_to_unsigned_parser.sv
// String to unsigned integer parser, one character per request.
// Input channel (in_valid / in_stall / in_data): one byte of a string with the
// radix (sampled on the first character of each string) and a last flag. A NUL
// byte also ends the string and is not counted as part of it.
// Result channel (out_valid / out_stall / out_data): one request per string,
// carrying the value, the offset of the first character not consumed and a
// status (ok, overflow, invalid radix, minus sign).
// Throughput: one character per cycle, except while a string end waits on a held
// result register; the per-character step is a single multiply-add of the
// accumulator by the radix, done on the character held in the input register.
// Path: an accepted character is held in the input register, then processed into
// the parse state, or for a string end into the result register that drives out_data.
// Stall: the output register holds a finished result while out_stall is high.
// Characters that do not end a string keep flowing; a string end waits in the
// input register, and in_stall rises only then.
// Reset: synchronous, active low; clears all parse state and both valid flags,
// so the next character starts a new string.
module string_to_unsigned_parser #(
  parameter int WORD_BITS = stou_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stou_pkg::stou_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stou_pkg::stou_out_t out_data
);
  import stou_pkg::*;

  localparam int PW = WORD_BITS + 7;
  localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}};

  // input register
  logic      s1_valid_r, s1_valid_nxt;
  stou_in_t  s1_data_r;

  // parse state
  phase_t                phase_r, phase_nxt;
  logic [5:0]            radix_r, radix_nxt;
  logic [WORD_BITS-1:0]  acc_r, acc_nxt;
  status_t               err_r, err_nxt;
  logic [15:0]           idx_r, idx_nxt;
  logic [15:0]           endpos_r, endpos_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  stou_out_t out_r, out_nxt;

  logic       in_accept;
  logic       advance;
  logic       emit;
  logic       first;
  logic       bad_radix;
  logic [5:0] rad0;
  phase_t     ph0;
  phase_t     ph_eff;
  status_t    err0;
  logic [5:0] dig;
  logic [5:0] rad_td;
  logic [PW-1:0] prod;
  logic       prod_ovf;
  logic [15:0] pos_next;
  logic [7:0]  ch;

  assign ch   = s1_data_r.character;
  assign emit = (ch == CH_NUL) || s1_data_r.last;

  // a string end needs the result register free; other characters always move
  assign advance   = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign s1_valid_nxt = in_accept || (s1_valid_r && !advance);

  // radix sampled on the first character of a string
  assign first     = (idx_r == 16'd0) && (phase_r == PH_SKIP);
  assign bad_radix = first && ((s1_data_r.radix == RADIX_BAD) ||
                               (s1_data_r.radix > RADIX_MAX));
  assign rad0 = first ? s1_data_r.radix : radix_r;
  assign ph0  = bad_radix ? PH_DONE : phase_r;
  assign err0 = bad_radix ? ST_BADRADIX : err_r;

  assign dig      = digit_of(ch);
  assign pos_next = (idx_r < IDX_LIMIT) ? idx_r + 16'd1 : IDX_LIMIT;

  // a plain character while skipping white space is handled as after the sign
  always_comb begin
    ph_eff = ph0;
    if (ph0 == PH_SKIP && !is_space(ch) && ch != CH_MINUS && ch != CH_PLUS) begin
      ph_eff = PH_SIGNED;
    end
  end

  // radix that the digit step uses, with automatic radix resolved
  always_comb begin
    rad_td = rad0;
    if (rad0 == RADIX_AUTO) begin
      if (ph_eff == PH_SIGNED) begin
        rad_td = RADIX_DEC;
      end else if (ph_eff == PH_ZERO) begin
        rad_td = RADIX_OCT;
      end
    end
  end

  // one multiply-add; overflow when anything lands above the word
  assign prod     = PW'(acc_r) * PW'(rad_td) + PW'(dig);
  assign prod_ovf = |prod[PW-1:WORD_BITS];

  always_comb begin
    phase_nxt  = ph0;
    radix_nxt  = rad0;
    acc_nxt    = acc_r;
    err_nxt    = err0;
    idx_nxt    = idx_r;
    endpos_nxt = endpos_r;

    if (ch != CH_NUL) begin
      if (idx_r < IDX_LIMIT) begin
        idx_nxt = idx_r + 16'd1;
      end
      unique case (ph_eff)
        PH_SKIP: begin
          if (ch == CH_MINUS) begin
            err_nxt   = ST_MINUS;
            phase_nxt = PH_DONE;
          end else if (ch == CH_PLUS) begin
            phase_nxt = PH_SIGNED;
          end
        end
        PH_SIGNED, PH_ZERO, PH_XSEEN, PH_DIGITS: begin
          if (ph_eff == PH_SIGNED && ch == CH_ZERO &&
              (rad0 == RADIX_AUTO || rad0 == RADIX_HEX)) begin
            // leading zero, may open a hex prefix
            endpos_nxt = pos_next;
            acc_nxt    = '0;
            phase_nxt  = PH_ZERO;
          end else if (ph_eff == PH_ZERO && (ch == CH_LX || ch == CH_UX)) begin
            radix_nxt = RADIX_HEX;
            phase_nxt = PH_XSEEN;
          end else begin
            radix_nxt = rad_td;
            if (dig >= rad_td) begin
              phase_nxt = PH_DONE;
            end else begin
              if (err0 == ST_OK) begin
                if (prod_ovf) begin
                  err_nxt = ST_OVERFLOW;
                  acc_nxt = '0;
                end else begin
                  acc_nxt = prod[WORD_BITS-1:0];
                end
              end
              endpos_nxt = pos_next;
              phase_nxt  = PH_DIGITS;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result assembly and output register control
  always_comb begin
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_nxt.value      = (err_nxt == ST_OK) ? 64'(acc_nxt & WORD_MASK) : 64'd0;
    out_nxt.end_offset = (err_nxt == ST_BADRADIX || err_nxt == ST_MINUS) ? 16'd0 : endpos_nxt;
    out_nxt.status     = err_nxt;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_nxt = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SKIP;
      radix_r     <= RADIX_AUTO;
      acc_r       <= '0;
      err_r       <= ST_OK;
      idx_r       <= 16'd0;
      endpos_r    <= 16'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        if (emit) begin
          // string done, back to a clean start
          phase_r  <= PH_SKIP;
          radix_r  <= RADIX_AUTO;
          acc_r    <= '0;
          err_r    <= ST_OK;
          idx_r    <= 16'd0;
          endpos_r <= 16'd0;
        end else begin
          phase_r  <= phase_nxt;
          radix_r  <= radix_nxt;
          acc_r    <= acc_nxt;
          err_r    <= err_nxt;
          idx_r    <= idx_nxt;
          endpos_r <= endpos_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
